// ===== rtl/core/vhs_pkg.sv =====
// Shared types, constants and the arctangent table for the spiral sampler.
// No dependencies; every other file in rtl/core takes names from here.
package vhs_pkg;

   localparam int FRACTION_BITS_DEF = 14;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int IDX_W   = 16;
   localparam int DIR_W   = 16;
   localparam int AXIS_W  = 16;
   localparam int AXES_W  = 48;
   localparam int DEN_W   = 17;
   localparam int ANG_W   = 32;
   localparam int Z_W     = 34;
   localparam int CSR_AW  = 6;
   localparam int CSR_DW  = 64;

   localparam int GUARD_BITS = 8;
   localparam int GAIN_FRAC  = 30;

   // 2.4 rad as a fraction of a turn at 2^32 scale
   localparam logic [ANG_W-1:0] ANGLE_STEP = 32'd1640556661;
   // 1/K of the CORDIC rotation, Q30
   localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q30 = 30'd652032874;

   localparam logic [15:0]       COUNT_RST     = 16'd64;
   localparam logic [15:0]       PHASE_RST     = 16'd0;
   localparam logic [AXES_W-1:0] NORMAL_RST    = 48'h0000_4000_0000;
   localparam logic [AXES_W-1:0] TANGENT_RST   = 48'h0000_0000_4000;
   localparam logic [AXES_W-1:0] BITANGENT_RST = 48'h4000_0000_0000;

   typedef enum logic [2:0] {
      REG_SAMPLE_COUNT   = 3'd0,
      REG_ROTATION_PHASE = 3'd1,
      REG_NORMAL_AXIS    = 3'd2,
      REG_TANGENT_AXIS   = 3'd3,
      REG_BITANGENT_AXIS = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic enable;
      logic valid;
   } pipe_ctl_type;

   // atan(2^-k) in turns, 2^32 scale
   function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] k);
      logic [ANG_W-1:0] v;
      case (k)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/vhs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for r^2.
// Depends on vhs_pkg.
module vhs_div #(
   parameter int FRACTION_BITS = vhs_pkg::FRACTION_BITS_DEF,
   parameter int SIDE_W        = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  vhs_pkg::pipe_ctl_type          ctl,
   input  logic [FRACTION_BITS+17:0]      num,
   input  logic [vhs_pkg::DEN_W-1:0]      den,
   input  logic                           sat,
   input  logic [SIDE_W-1:0]              side_in,
   output logic                           out_valid,
   output logic [FRACTION_BITS+1:0]       quot,
   output logic [SIDE_W-1:0]              side_out
);
   localparam int NW     = FRACTION_BITS + 18;
   localparam int QW     = FRACTION_BITS + 2;
   localparam int STAGES = QW;
   localparam int DW     = vhs_pkg::DEN_W;

   logic              vld_ff  [STAGES];
   logic [NW-1:0]     rem_ff  [STAGES];
   logic [DW-1:0]     den_ff  [STAGES];
   logic [QW-1:0]     quot_ff [STAGES];
   logic              sat_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int B = QW - 1 - j;
      logic              vld_src;
      logic [NW-1:0]     rem_src;
      logic [DW-1:0]     den_src;
      logic [QW-1:0]     quot_src;
      logic              sat_src;
      logic [SIDE_W-1:0] side_src;
      logic [NW:0]       trial;
      logic              take;

      if (j == 0) begin : g_first
         assign vld_src  = ctl.valid;
         assign rem_src  = num;
         assign den_src  = den;
         assign quot_src = '0;
         assign sat_src  = sat;
         assign side_src = side_in;
      end else begin : g_next
         assign vld_src  = vld_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign quot_src = quot_ff[j-1];
         assign sat_src  = sat_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      assign trial = (NW+1)'(den_src) << B;
      assign take  = {1'b0, rem_src} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (ctl.enable) begin
            vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            rem_ff[j]  <= take ? NW'({1'b0, rem_src} - trial) : rem_src;
            den_ff[j]  <= den_src;
            quot_ff[j] <= quot_src | (take ? (QW'(1) << B) : QW'(0));
            sat_ff[j]  <= sat_src;
            side_ff[j] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign quot      = sat_ff[STAGES-1] ? '1 : quot_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];

   // an unsaturated quotient leaves a proper remainder
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1] && !sat_ff[STAGES-1]
      |-> (NW+1)'(rem_ff[STAGES-1]) < (NW+1)'(den_ff[STAGES-1]))
      else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/vhs_sqrt.sv =====
// Two-lane pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on vhs_pkg.
module vhs_sqrt #(
   parameter int FRACTION_BITS = vhs_pkg::FRACTION_BITS_DEF,
   parameter int SIDE_W        = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vhs_pkg::pipe_ctl_type         ctl,
   input  logic [2*FRACTION_BITS+1:0]    rad [2],
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   output logic [FRACTION_BITS:0]        root [2],
   output logic [SIDE_W-1:0]             side_out
);
   localparam int RW     = 2 * FRACTION_BITS + 2;
   localparam int OW     = FRACTION_BITS + 1;
   localparam int STAGES = OW;

   logic              vld_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [RW-1:0]     rem_ff  [STAGES][2];
   logic [OW-1:0]     root_ff [STAGES][2];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int B = OW - 1 - j;
      logic              vld_src;
      logic [SIDE_W-1:0] side_src;

      if (j == 0) begin : g_first
         assign vld_src  = ctl.valid;
         assign side_src = side_in;
      end else begin : g_next
         assign vld_src  = vld_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (ctl.enable) begin
            vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            side_ff[j] <= side_src;
         end
      end

      for (genvar n = 0; n < 2; n++) begin : g_lane
         logic [RW-1:0] rem_src;
         logic [OW-1:0] root_src;
         logic [RW:0]   trial;
         logic          take;

         if (j == 0) begin : g_first
            assign rem_src  = rad[n];
            assign root_src = '0;
         end else begin : g_next
            assign rem_src  = rem_ff[j-1][n];
            assign root_src = root_ff[j-1][n];
         end

         // (root + 2^B)^2 - root^2
         assign trial = ((RW+1)'(root_src) << (B + 1)) + ((RW+1)'(1) << (2 * B));
         assign take  = {1'b0, rem_src} >= trial;

         always_ff @(posedge clock) begin
            if (ctl.enable) begin
               rem_ff[j][n]  <= take ? RW'({1'b0, rem_src} - trial) : rem_src;
               root_ff[j][n] <= root_src | (take ? (OW'(1) << B) : OW'(0));
            end
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign root[0]   = root_ff[STAGES-1][0];
   assign root[1]   = root_ff[STAGES-1][1];
   assign side_out  = side_ff[STAGES-1];

   // floor root: leftover never exceeds 2*root
   a_root_floor_0: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1]
      |-> (RW+1)'(rem_ff[STAGES-1][0]) <= (RW+1)'({root_ff[STAGES-1][0], 1'b0}))
      else $error("radius root not floor");
   a_root_floor_1: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1]
      |-> (RW+1)'(rem_ff[STAGES-1][1]) <= (RW+1)'({root_ff[STAGES-1][1], 1'b0}))
      else $error("height root not floor");

endmodule

// ===== rtl/core/vhs_cordic.sv =====
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on vhs_pkg (arctangent table, angle width).
module vhs_cordic #(
   parameter int FRACTION_BITS = vhs_pkg::FRACTION_BITS_DEF,
   parameter int CORDIC_STAGES = vhs_pkg::CORDIC_STAGES_DEF,
   parameter int SIDE_W        = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vhs_pkg::pipe_ctl_type               ctl,
   input  logic signed [FRACTION_BITS+10:0]    x0,
   input  logic signed [vhs_pkg::Z_W-1:0]      z0,
   input  logic [SIDE_W-1:0]                   side_in,
   output logic                                out_valid,
   output logic signed [FRACTION_BITS+10:0]    x_out,
   output logic signed [FRACTION_BITS+10:0]    y_out,
   output logic [SIDE_W-1:0]                   side_out
);
   localparam int XW = FRACTION_BITS + 11;
   localparam int ZW = vhs_pkg::Z_W;

   logic                 vld_ff  [CORDIC_STAGES];
   logic signed [XW-1:0] x_ff    [CORDIC_STAGES];
   logic signed [XW-1:0] y_ff    [CORDIC_STAGES];
   logic signed [ZW-1:0] z_ff    [CORDIC_STAGES];
   logic [SIDE_W-1:0]    side_ff [CORDIC_STAGES];

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      logic                 vld_src;
      logic signed [XW-1:0] x_src;
      logic signed [XW-1:0] y_src;
      logic signed [ZW-1:0] z_src;
      logic [SIDE_W-1:0]    side_src;
      logic signed [ZW-1:0] step;

      if (k == 0) begin : g_first
         assign vld_src  = ctl.valid;
         assign x_src    = x0;
         assign y_src    = '0;
         assign z_src    = z0;
         assign side_src = side_in;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign x_src    = x_ff[k-1];
         assign y_src    = y_ff[k-1];
         assign z_src    = z_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign step = ZW'(vhs_pkg::atan_turn(5'(k)));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl.enable) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            side_ff[k] <= side_src;
            if (!z_src[ZW-1]) begin
               x_ff[k] <= x_src - (y_src >>> k);
               y_ff[k] <= y_src + (x_src >>> k);
               z_ff[k] <= z_src - step;
            end else begin
               x_ff[k] <= x_src + (y_src >>> k);
               y_ff[k] <= y_src - (x_src >>> k);
               z_ff[k] <= z_src + step;
            end
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STAGES-1];
   assign x_out     = x_ff[CORDIC_STAGES-1];
   assign y_out     = y_ff[CORDIC_STAGES-1];
   assign side_out  = side_ff[CORDIC_STAGES-1];

endmodule

// ===== rtl/core/vogel_hemisphere_sample.sv =====
// Vogel spiral hemisphere sampler: one sample_index word in, one direction word out.
// Depends on vhs_pkg, vhs_div, vhs_sqrt and vhs_cordic.
//
// Fully pipelined: a new index is taken every cycle unless the output word is held.
// The depth is, in order, the bit-per-stage divider for r^2, the bit-per-stage
// square roots for radius and height, the gain scale register, the CORDIC
// rotation and the axis multiply and sum.
// When the output word is held, the whole pipe holds with it. Registers are
// read live by the pipe, so write them only while no sample is in flight.
module vogel_hemisphere_sample #(
   parameter int FRACTION_BITS = vhs_pkg::FRACTION_BITS_DEF,
   parameter int CORDIC_STAGES = vhs_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [vhs_pkg::IDX_W-1:0]          req_sample_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vhs_pkg::DIR_W-1:0]   rsp_dir_x,
   output logic signed [vhs_pkg::DIR_W-1:0]   rsp_dir_y,
   output logic signed [vhs_pkg::DIR_W-1:0]   rsp_dir_z,
   output logic                               rsp_index_beyond_count,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vhs_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [vhs_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [vhs_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);
   localparam int F    = FRACTION_BITS;
   localparam int NW   = F + 18;
   localparam int QW   = F + 2;
   localparam int RW   = 2 * F + 2;
   localparam int OW   = F + 1;
   localparam int XW   = F + 11;
   localparam int PXW  = F + 3;
   localparam int PW   = F + 19;
   localparam int SW   = PW + 2;
   localparam int GW   = F + 1 + vhs_pkg::GAIN_FRAC;
   localparam int AW   = vhs_pkg::ANG_W;
   localparam int ZW   = vhs_pkg::Z_W;
   localparam int DW   = vhs_pkg::DEN_W;
   localparam int XS   = vhs_pkg::AXIS_W;
   localparam int SIDE_A = AW + 2;
   localparam int SIDE_C = OW + 2;
   localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
   localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

   // ---------------- register file ----------------
   logic [15:0]                 count_ff;
   logic [15:0]                 phase_ff;
   logic [vhs_pkg::AXES_W-1:0]  normal_ff;
   logic [vhs_pkg::AXES_W-1:0]  tangent_ff;
   logic [vhs_pkg::AXES_W-1:0]  bitan_ff;
   logic                        csr_wr;
   logic [2:0]                  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= vhs_pkg::COUNT_RST;
         phase_ff   <= vhs_pkg::PHASE_RST;
         normal_ff  <= vhs_pkg::NORMAL_RST;
         tangent_ff <= vhs_pkg::TANGENT_RST;
         bitan_ff   <= vhs_pkg::BITANGENT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            vhs_pkg::REG_SAMPLE_COUNT:   count_ff   <= csr_pwdata[15:0];
            vhs_pkg::REG_ROTATION_PHASE: phase_ff   <= csr_pwdata[15:0];
            vhs_pkg::REG_NORMAL_AXIS:    normal_ff  <= csr_pwdata[47:0];
            vhs_pkg::REG_TANGENT_AXIS:   tangent_ff <= csr_pwdata[47:0];
            vhs_pkg::REG_BITANGENT_AXIS: bitan_ff   <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         vhs_pkg::REG_SAMPLE_COUNT:   csr_prdata = 64'(count_ff);
         vhs_pkg::REG_ROTATION_PHASE: csr_prdata = 64'(phase_ff);
         vhs_pkg::REG_NORMAL_AXIS:    csr_prdata = 64'(normal_ff);
         vhs_pkg::REG_TANGENT_AXIS:   csr_prdata = 64'(tangent_ff);
         vhs_pkg::REG_BITANGENT_AXIS: csr_prdata = 64'(bitan_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------- pipe control ----------------
   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- entry: divide setup and spiral angle ----------------
   logic [15:0]    count_eff;
   logic [DW-1:0]  odd;
   logic [NW-1:0]  num;
   logic [DW-1:0]  den;
   logic           sat;
   logic           beyond;
   logic [AW-1:0]  ang;
   logic           fold;
   logic [AW-1:0]  ang_f;

   assign count_eff = (count_ff == 16'd0) ? 16'd1 : count_ff;
   assign odd       = {req_sample_index, 1'b1};
   assign num       = NW'(odd) << F;
   assign den       = {count_eff, 1'b0};
   // quotient would reach 4.0
   assign sat       = 20'(odd) >= 20'({count_eff, 3'b000});
   assign beyond    = req_sample_index >= count_eff;
   assign ang       = (AW'(req_sample_index) * vhs_pkg::ANGLE_STEP) + {phase_ff, 16'd0};
   // fold second and third quadrants by a half turn, negate the result later
   assign fold      = ang[AW-1] ^ ang[AW-2];
   assign ang_f     = fold ? {~ang[AW-1], ang[AW-2:0]} : ang;

   logic              div_valid;
   logic [QW-1:0]     r2;
   logic [SIDE_A-1:0] div_side;

   vhs_div #(.FRACTION_BITS(F), .SIDE_W(SIDE_A)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      ('{enable: en, valid: req_valid}),
      .num      (num),
      .den      (den),
      .sat      (sat),
      .side_in  ({fold, beyond, ang_f}),
      .out_valid(div_valid),
      .quot     (r2),
      .side_out (div_side)
   );

   // ---------------- radius and height roots ----------------
   logic          div_beyond;
   logic [OW-1:0] one_m_r2;
   logic [RW-1:0] rad [2];

   assign div_beyond = div_side[AW];
   assign one_m_r2   = (div_beyond || (r2 >= QW'(1) << F)) ? '0
                       : OW'((QW'(1) << F) - r2);
   assign rad[0]     = RW'(r2) << F;
   assign rad[1]     = RW'(one_m_r2) << F;

   logic              sq_valid;
   logic [OW-1:0]     root [2];
   logic [SIDE_A-1:0] sq_side;

   vhs_sqrt #(.FRACTION_BITS(F), .SIDE_W(SIDE_A)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      ('{enable: en, valid: div_valid}),
      .rad      (rad),
      .side_in  (div_side),
      .out_valid(sq_valid),
      .root     (root),
      .side_out (sq_side)
   );

   // ---------------- gain scale ----------------
   logic [GW-1:0]        gprod;
   logic                 gain_vld_ff;
   logic signed [XW-1:0] gain_x_ff;
   logic [OW-1:0]        gain_h_ff;
   logic                 gain_neg_ff;
   logic                 gain_beyond_ff;
   logic [AW-1:0]        gain_ang_ff;

   assign gprod = GW'(root[0]) * GW'(vhs_pkg::INV_GAIN_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_vld_ff <= 1'b0;
      end else if (en) begin
         gain_vld_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gain_x_ff      <= XW'(gprod >> (vhs_pkg::GAIN_FRAC - vhs_pkg::GUARD_BITS));
         gain_h_ff      <= root[1];
         gain_neg_ff    <= sq_side[AW+1];
         gain_beyond_ff <= sq_side[AW];
         gain_ang_ff    <= sq_side[AW-1:0];
      end
   end

   // ---------------- rotation ----------------
   logic signed [ZW-1:0] z0;
   logic                 cor_valid;
   logic signed [XW-1:0] cor_x;
   logic signed [XW-1:0] cor_y;
   logic [SIDE_C-1:0]    cor_side;

   assign z0 = ZW'($signed(gain_ang_ff));

   vhs_cordic #(.FRACTION_BITS(F), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(SIDE_C)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .ctl      ('{enable: en, valid: gain_vld_ff}),
      .x0       (gain_x_ff),
      .z0       (z0),
      .side_in  ({gain_neg_ff, gain_beyond_ff, gain_h_ff}),
      .out_valid(cor_valid),
      .x_out    (cor_x),
      .y_out    (cor_y),
      .side_out (cor_side)
   );

   // ---------------- axis products ----------------
   logic signed [PXW-1:0] px_raw;
   logic signed [PXW-1:0] py_raw;
   logic signed [PXW-1:0] px;
   logic signed [PXW-1:0] py;
   logic signed [PW-1:0]  px_w;
   logic signed [PW-1:0]  py_w;
   logic signed [PW-1:0]  h_w;
   logic signed [PW-1:0]  ax_t [3];
   logic signed [PW-1:0]  ax_n [3];
   logic signed [PW-1:0]  ax_b [3];

   assign px_raw = PXW'(cor_x >>> vhs_pkg::GUARD_BITS);
   assign py_raw = PXW'(cor_y >>> vhs_pkg::GUARD_BITS);
   assign px     = cor_side[OW+1] ? -px_raw : px_raw;
   assign py     = cor_side[OW+1] ? -py_raw : py_raw;
   assign px_w   = px;
   assign py_w   = py;
   assign h_w    = PW'(cor_side[OW-1:0]);

   for (genvar c = 0; c < 3; c++) begin : g_axis
      assign ax_t[c] = $signed(tangent_ff[XS*c +: XS]);
      assign ax_n[c] = $signed(normal_ff[XS*c +: XS]);
      assign ax_b[c] = $signed(bitan_ff[XS*c +: XS]);
   end

   logic                 mul_vld_ff;
   logic                 mul_beyond_ff;
   logic signed [PW-1:0] mt_ff [3];
   logic signed [PW-1:0] mn_ff [3];
   logic signed [PW-1:0] mb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (en) begin
         mul_vld_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_beyond_ff <= cor_side[OW];
         for (int c = 0; c < 3; c++) begin
            mt_ff[c] <= px_w * ax_t[c];
            mn_ff[c] <= h_w * ax_n[c];
            mb_ff[c] <= py_w * ax_b[c];
         end
      end
   end

   // ---------------- sum, round half up, saturate ----------------
   logic signed [SW-1:0] half;
   logic signed [SW-1:0] s_t [3];
   logic signed [SW-1:0] s_n [3];
   logic signed [SW-1:0] s_b [3];
   logic signed [SW-1:0] s_rnd [3];
   logic signed [vhs_pkg::DIR_W-1:0] s_sat [3];

   assign half = SW'(1) << (F - 1);

   for (genvar c = 0; c < 3; c++) begin : g_sum
      assign s_t[c]   = mt_ff[c];
      assign s_n[c]   = mn_ff[c];
      assign s_b[c]   = mb_ff[c];
      assign s_rnd[c] = (s_t[c] + s_n[c] + s_b[c] + half) >>> F;
      assign s_sat[c] = (s_rnd[c] > SAT_HI) ? vhs_pkg::DIR_W'(SAT_HI)
                      : (s_rnd[c] < SAT_LO) ? vhs_pkg::DIR_W'(SAT_LO)
                      : vhs_pkg::DIR_W'(s_rnd[c]);
   end

   logic signed [vhs_pkg::DIR_W-1:0] dir_x_ff;
   logic signed [vhs_pkg::DIR_W-1:0] dir_y_ff;
   logic signed [vhs_pkg::DIR_W-1:0] dir_z_ff;
   logic                             beyond_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_x_ff  <= s_sat[0];
         dir_y_ff  <= s_sat[1];
         dir_z_ff  <= s_sat[2];
         beyond_ff <= mul_beyond_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_dir_x              = dir_x_ff;
   assign rsp_dir_y              = dir_y_ff;
   assign rsp_dir_z              = dir_z_ff;
   assign rsp_index_beyond_count = beyond_ff;

   // index past the count must come out of the root stage with zero height
   a_beyond_zero_height: assert property (@(posedge clock) disable iff (reset)
      sq_valid && sq_side[AW] |-> root[1] == '0)
      else $error("height not clamped for index beyond count");

endmodule

// ===== bench/vhs_checker.sv =====
`timescale 1ns / 1ps
// Checker for the spiral sampler: watches both channels and the register port,
// predicts each direction word and compares it. Depends on vhs_pkg.
module vhs_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [vhs_pkg::IDX_W-1:0]        req_sample_index,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [vhs_pkg::DIR_W-1:0] rsp_dir_x,
   input  logic signed [vhs_pkg::DIR_W-1:0] rsp_dir_y,
   input  logic signed [vhs_pkg::DIR_W-1:0] rsp_dir_z,
   input  logic                             rsp_index_beyond_count,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vhs_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [vhs_pkg::CSR_DW-1:0]       csr_pwdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               pending
);
   localparam int F = vhs_pkg::FRACTION_BITS_DEF;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               beyond;
   } dir_word_type;

   logic [15:0]  count_q, phase_q;
   logic [47:0]  normal_q, tangent_q, bitan_q;
   dir_word_type dir_queue[$];

   assign pending = dir_queue.size();

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic longint axis_part(input logic [47:0] p, input int c);
      return longint'($signed(p[16*c +: 16]));
   endfunction

   function automatic dir_word_type hemisphere_dir(input logic [15:0] idx);
      dir_word_type w;
      longint unsigned cnt, r2, r, h;
      logic [31:0] ang;
      logic neg;
      longint x, y, z, dx, dy, px, py, s;
      cnt = (count_q == 0) ? 1 : count_q;
      w.beyond = idx >= cnt;
      r2 = (((2 * longint'(idx)) + 1) << F) / (2 * cnt);
      if (r2 > (4 << F) - 1) r2 = (4 << F) - 1;
      r = int_sqrt(r2 << F);
      h = (w.beyond || r2 >= (1 << F)) ? 0 : int_sqrt(((1 << F) - r2) << F);
      ang = idx * vhs_pkg::ANGLE_STEP + {phase_q, 16'd0};
      neg = 0;
      if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
         ang -= 32'h8000_0000;
         neg = 1;
      end
      z = longint'($signed(ang));
      x = longint'((r * vhs_pkg::INV_GAIN_Q30)
                   >> (vhs_pkg::GAIN_FRAC - vhs_pkg::GUARD_BITS));
      y = 0;
      for (int k = 0; k < vhs_pkg::CORDIC_STAGES_DEF; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(vhs_pkg::atan_turn(k[4:0]));
         end else begin
            x += dx; y -= dy; z += longint'(vhs_pkg::atan_turn(k[4:0]));
         end
      end
      px = x >>> vhs_pkg::GUARD_BITS;
      py = y >>> vhs_pkg::GUARD_BITS;
      if (neg) begin
         px = -px; py = -py;
      end
      for (int c = 0; c < 3; c++) begin
         s = px * axis_part(tangent_q, c) + longint'(h) * axis_part(normal_q, c)
             + py * axis_part(bitan_q, c);
         s = (s + (64'sd1 <<< (F - 1))) >>> F;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         case (c)
            0: w.x = s[15:0];
            1: w.y = s[15:0];
            default: w.z = s[15:0];
         endcase
      end
      return w;
   endfunction

   always @(posedge clock) begin
      dir_word_type e;
      if (reset) begin
         count_q   <= vhs_pkg::COUNT_RST;
         phase_q   <= vhs_pkg::PHASE_RST;
         normal_q  <= vhs_pkg::NORMAL_RST;
         tangent_q <= vhs_pkg::TANGENT_RST;
         bitan_q   <= vhs_pkg::BITANGENT_RST;
         fail_count <= 0;
         dir_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               vhs_pkg::REG_SAMPLE_COUNT:   count_q   <= csr_pwdata[15:0];
               vhs_pkg::REG_ROTATION_PHASE: phase_q   <= csr_pwdata[15:0];
               vhs_pkg::REG_NORMAL_AXIS:    normal_q  <= csr_pwdata[47:0];
               vhs_pkg::REG_TANGENT_AXIS:   tangent_q <= csr_pwdata[47:0];
               vhs_pkg::REG_BITANGENT_AXIS: bitan_q   <= csr_pwdata[47:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) dir_queue.push_back(hemisphere_dir(req_sample_index));
         if (rsp_valid && rsp_ready) begin
            if (dir_queue.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                        rsp_dir_x, rsp_dir_y, rsp_dir_z);
               fail_count <= fail_count + 1;
            end else begin
               e = dir_queue.pop_front();
               if (e.x !== rsp_dir_x || e.y !== rsp_dir_y || e.z !== rsp_dir_z ||
                   e.beyond !== rsp_index_beyond_count) begin
                  $display("%0t: expected x=%0d y=%0d z=%0d b=%0b got x=%0d y=%0d z=%0d b=%0b",
                           $time, e.x, e.y, e.z, e.beyond, rsp_dir_x, rsp_dir_y,
                           rsp_dir_z, rsp_index_beyond_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the spiral sampler bench: clock, reset, register writes, index stimulus
// and the verdict. Depends on vhs_pkg, vhs_checker and the sampler RTL.
module tb_top;
   localparam int LATENCY = 2 * vhs_pkg::FRACTION_BITS_DEF + vhs_pkg::CORDIC_STAGES_DEF + 6;
   localparam longint CYCLE_LIMIT = 600000;

   localparam logic [15:0] DIRECTED_A [8] = '{16'd0, 16'd1, 16'd31, 16'd63, 16'd64,
                                              16'd65, 16'd255, 16'hFFFF};
   localparam logic [15:0] DIRECTED_B [5] = '{16'd0, 16'd1, 16'h5555, 16'hAAAA, 16'hFFFF};
   localparam logic [15:0] DIRECTED_C [4] = '{16'd0, 16'h7FFF, 16'hFFFE, 16'hFFFF};

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [15:0] req_sample_index = 0;
   logic req_ready, rsp_valid, rsp_index_beyond_count, csr_pready;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [vhs_pkg::CSR_AW-1:0] csr_paddr = 0;
   logic [vhs_pkg::CSR_DW-1:0] csr_pwdata = 0, csr_prdata;
   int fail_count, pending;
   int send_idle = 0, recv_stall = 0;
   longint cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   vogel_hemisphere_sample u_dut (.*);

   vhs_checker u_chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall);

   task automatic write_reg(input vhs_pkg::reg_index_type idx, input logic [63:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= val;
      @(negedge clock) csr_penable <= 1;
      @(negedge clock) begin
         csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic send_index(input logic [15:0] idx);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_sample_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [47:0] rand_axis();
      logic [15:0] c[3];
      foreach (c[i]) begin
         case ($urandom_range(3))
            0: c[i] = 16'h4000;
            1: c[i] = 16'hC000;
            2: c[i] = 16'($urandom());
            default: c[i] = 16'($signed($urandom_range(32768)) - 16384);
         endcase
      end
      return {c[2], c[1], c[0]};
   endfunction

   function automatic logic [15:0] rand_index(input logic [15:0] cnt);
      case ($urandom_range(9))
         0: return 16'($urandom());
         1: return cnt;
         2: return 16'hFFFF;
         default: return (cnt == 0) ? 16'd0 : 16'($urandom_range(cnt - 1));
      endcase
   endfunction

   initial begin
      logic [15:0] cnt;
      int ph;
      repeat (3) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: reset settings, index extremes, beyond count, zero count
      for (int i = 0; i < 8; i++) send_index(DIRECTED_A[i]);
      drain();
      write_reg(vhs_pkg::REG_SAMPLE_COUNT, 64'd0);
      write_reg(vhs_pkg::REG_ROTATION_PHASE, 64'hFFFF);
      write_reg(vhs_pkg::REG_NORMAL_AXIS, 64'h7FFF_8000_7FFF);
      write_reg(vhs_pkg::REG_TANGENT_AXIS, 64'h8000_7FFF_8000);
      write_reg(vhs_pkg::REG_BITANGENT_AXIS, 64'h7FFF_7FFF_7FFF);
      for (int i = 0; i < 5; i++) send_index(DIRECTED_B[i]);
      drain();
      write_reg(vhs_pkg::REG_SAMPLE_COUNT, 64'hFFFF);
      write_reg(vhs_pkg::REG_ROTATION_PHASE, 64'h8000);
      for (int i = 0; i < 4; i++) send_index(DIRECTED_C[i]);
      drain();
      // random phases with idle and stall patterns
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 79; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 79; end
            default: begin send_idle = 22; recv_stall = 22; end
         endcase
         ph = $urandom_range(3);
         cnt = (ph == 0) ? 16'd1 : (ph == 1) ? 16'hFFFF : 16'($urandom_range(1, 300));
         write_reg(vhs_pkg::REG_SAMPLE_COUNT, 64'(cnt));
         write_reg(vhs_pkg::REG_ROTATION_PHASE, 64'($urandom_range(16'hFFFF)));
         write_reg(vhs_pkg::REG_NORMAL_AXIS, 64'(rand_axis()));
         write_reg(vhs_pkg::REG_TANGENT_AXIS, 64'(rand_axis()));
         write_reg(vhs_pkg::REG_BITANGENT_AXIS, 64'(rand_axis()));
         for (int n = 0; n < 125; n++) send_index(rand_index(cnt));
         drain();
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
